/* sv/fcc_pkg.sv */
package fcc_pkg;

   localparam int CH_W       = 20;
   localparam int SAMPLES_W  = 48;
   localparam int TODO_W     = 17;
   localparam int FRAME_W    = 17;
   localparam int SPP_W      = 16;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int REF_W      = 3 * CH_W;

   localparam logic [TODO_W-1:0] TODO_MAX  = '1;
   localparam logic [CH_W-1:0]   ERROR_INF = '1;

   typedef enum logic [1:0] {
      PASS_WARMUP  = 2'd0,
      PASS_STEP    = 2'd1,
      PASS_FIRST   = 2'd2,
      PASS_COMPARE = 2'd3
   } pass_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERROR_THRESHOLD = 2'd0,
      CSR_WARMUP_SPP      = 2'd1,
      CSR_STEP_SPP        = 2'd2,
      CSR_FRAME_PIXELS    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLES_W-1:0] total_samples;
      logic [CH_W-1:0]      red;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      blue;
   } req_payload_type;

   typedef struct packed {
      logic [TODO_W-1:0] todo_count;
      logic [CH_W-1:0]   max_error;
      logic [1:0]        pass_kind;
   } rsp_payload_type;

endpackage

/* sv/fcc_ref_ram.sv */
module fcc_ref_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [fcc_pkg::REF_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [fcc_pkg::REF_W-1:0] rd_data
);
   import fcc_pkg::*;

   logic [REF_W-1:0] mem [DEPTH];
   logic [REF_W-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/frame_convergence_checker_core.sv */
// Frame convergence checker: takes one pixel per clock in raster order and,
// at the last pixel of each frame, returns one transaction with the count of
// pixels whose largest per-channel difference from the stored reference
// exceeds the threshold, the largest difference, and the pass kind (warmup
// skip, step skip, first pass, compared); only a compared pass updates the
// count and difference. The pass kind is decided from the total sample
// count of the frame's first pixel. Pixels move through three stages:
// accept and reference memory read, pass decision and difference, then
// accumulation into the output register. A sustained rate of one pixel per
// clock is set by the single-port-per-direction reference memory, read once
// per pixel and rewritten on first and compared passes; back-to-back accesses
// to the same entry are forwarded. Input stalls only while a finished frame
// result waits to be taken and the next frame's last pixel has reached the
// accumulation stage behind it. The reference memory needs no clearing after
// reset; the user must write configuration only while idle (unchecked).
module frame_convergence_checker_core #(
   parameter int MAX_PIXELS = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [fcc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fcc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fcc_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fcc_pkg::rsp_payload_type              rsp_payload
);
   import fcc_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam logic [FRAME_W-1:0] RESET_PIXELS =
      (MAX_PIXELS < 65536) ? FRAME_W'(MAX_PIXELS) : FRAME_W'(65536);

   // Clamp the frame size into 1 .. MAX_PIXELS.
   function automatic logic [FRAME_W-1:0] eff_pixels(input logic [FRAME_W-1:0] fp);
      logic [FRAME_W-1:0] p;
      p = fp;
      if (fp == '0) begin
         p = FRAME_W'(1);
      end else if (32'(fp) > 32'(MAX_PIXELS)) begin
         p = FRAME_W'(MAX_PIXELS);
      end
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CH_W-1:0]    threshold_ff;
   logic [SPP_W-1:0]   warmup_ff;
   logic [SPP_W-1:0]   step_ff;
   logic [FRAME_W-1:0] frame_pixels_ff;
   logic [FRAME_W-1:0] eff_p;
   logic [FRAME_W-1:0] csr_eff_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         warmup_ff       <= '0;
         step_ff         <= '0;
         frame_pixels_ff <= FRAME_W'(65536);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_ERROR_THRESHOLD: threshold_ff    <= csr_wdata[CH_W-1:0];
            CSR_WARMUP_SPP:      warmup_ff       <= csr_wdata[SPP_W-1:0];
            CSR_STEP_SPP:        step_ff         <= csr_wdata[SPP_W-1:0];
            CSR_FRAME_PIXELS:    frame_pixels_ff <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign eff_p     = eff_pixels(frame_pixels_ff);
   assign csr_eff_p = eff_pixels(csr_wdata[FRAME_W-1:0]);

   // ---------------------------------------------------------------------
   // Stage A: accept a pixel, advance the position, issue the memory read
   // ---------------------------------------------------------------------
   logic                 req_fire;
   logic [AW-1:0]        pos_ff;
   logic [AW-1:0]        pos_in;
   logic [31:0]          pos_inc;
   logic                 a_last;
   logic [SPP_W:0]       warmup_plus;
   logic [2*FRAME_W-1:0] warm_prod_in;
   logic [FRAME_W+SPP_W-1:0] step_prod_in;

   assign req_fire     = req_valid && req_ready;
   assign pos_inc      = 32'(pos_ff) + 32'd1;
   assign a_last       = (pos_inc >= 32'(eff_p));
   assign pos_in       = a_last ? '0 : pos_inc[AW-1:0];
   assign warmup_plus  = {1'b0, warmup_ff} + (SPP_W+1)'(1);
   // Per-frame sample thresholds; registered before the 48-bit compares.
   assign warm_prod_in = eff_p * FRAME_W'(warmup_plus);
   assign step_prod_in = eff_p * step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_fire) begin
         pos_ff <= pos_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: decide pass kind at first pixel, take channel differences
   // ---------------------------------------------------------------------
   logic                     b_valid_ff;
   req_payload_type          b_pix_ff;
   logic                     b_first_ff;
   logic                     b_last_ff;
   logic [AW-1:0]            b_addr_ff;
   logic [2*FRAME_W-1:0]     b_warm_ff;
   logic [FRAME_W+SPP_W-1:0] b_step_ff;
   logic                     byp_ff;
   logic                     byp_in;
   logic [REF_W-1:0]         byp_data_ff;
   logic [REF_W-1:0]         rd_data;
   logic [REF_W-1:0]         ref_word;
   logic [REF_W-1:0]         wr_data;
   logic                     wr_en;

   pass_kind_type            kind_ff;
   logic [SAMPLES_W-1:0]     last_test_ff;
   logic                     first_pending_ff;
   pass_kind_type            decided;
   pass_kind_type            b_kind;
   logic                     warm_skip;
   logic                     step_skip;
   logic [SAMPLES_W:0]       step_limit;
   logic [CH_W-1:0]          diff_r;
   logic [CH_W-1:0]          diff_g;
   logic [CH_W-1:0]          diff_b;
   logic [CH_W-1:0]          diff_rg;
   logic [CH_W-1:0]          b_diff;
   logic                     b_ready;
   logic                     b_fire;
   logic                     c_ready;

   assign b_ready   = !b_valid_ff || c_ready;
   assign req_ready = b_ready;
   assign b_fire    = b_valid_ff && c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_pix_ff    <= req_payload;
         b_first_ff  <= (pos_ff == '0);
         b_last_ff   <= a_last;
         b_addr_ff   <= pos_ff;
         b_warm_ff   <= warm_prod_in;
         b_step_ff   <= step_prod_in;
         byp_ff      <= byp_in;
         byp_data_ff <= wr_data;
      end
   end

   // Forward the write of the pixel leaving stage B when the pixel entering
   // reads the same entry (single-pixel frames, wrap to position zero).
   assign byp_in   = wr_en && (b_addr_ff == pos_ff);
   assign ref_word = byp_ff ? byp_data_ff : rd_data;

   // Pass decision; samples that went backwards fall into the step skip.
   assign warm_skip  = b_pix_ff.total_samples < SAMPLES_W'(b_warm_ff);
   assign step_limit = {1'b0, last_test_ff} + (SAMPLES_W+1)'(b_step_ff);
   assign step_skip  = {1'b0, b_pix_ff.total_samples} <= step_limit;

   always_comb begin
      if (warm_skip) begin
         decided = PASS_WARMUP;
      end else if (step_skip) begin
         decided = PASS_STEP;
      end else if (first_pending_ff) begin
         decided = PASS_FIRST;
      end else begin
         decided = PASS_COMPARE;
      end
   end

   assign b_kind = b_first_ff ? decided : kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff          <= PASS_WARMUP;
         last_test_ff     <= '0;
         first_pending_ff <= 1'b1;
      end else if (b_fire && b_first_ff) begin
         kind_ff <= decided;
         if (decided == PASS_FIRST || decided == PASS_COMPARE) begin
            last_test_ff <= b_pix_ff.total_samples;
         end
         if (decided == PASS_FIRST) begin
            first_pending_ff <= 1'b0;
         end
      end
   end

   assign diff_r = (b_pix_ff.red > ref_word[3*CH_W-1:2*CH_W])
                   ? b_pix_ff.red - ref_word[3*CH_W-1:2*CH_W]
                   : ref_word[3*CH_W-1:2*CH_W] - b_pix_ff.red;
   assign diff_g = (b_pix_ff.green > ref_word[2*CH_W-1:CH_W])
                   ? b_pix_ff.green - ref_word[2*CH_W-1:CH_W]
                   : ref_word[2*CH_W-1:CH_W] - b_pix_ff.green;
   assign diff_b = (b_pix_ff.blue > ref_word[CH_W-1:0])
                   ? b_pix_ff.blue - ref_word[CH_W-1:0]
                   : ref_word[CH_W-1:0] - b_pix_ff.blue;
   assign diff_rg = (diff_g > diff_r) ? diff_g : diff_r;
   assign b_diff  = (diff_b > diff_rg) ? diff_b : diff_rg;

   // Overwrite the reference on first and compared passes.
   assign wr_en   = b_fire && (b_kind == PASS_FIRST || b_kind == PASS_COMPARE);
   assign wr_data = {b_pix_ff.red, b_pix_ff.green, b_pix_ff.blue};

   fcc_ref_ram #(
      .DEPTH (MAX_PIXELS),
      .AW    (AW)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage C: accumulate count and maximum, load the output register
   // ---------------------------------------------------------------------
   logic              c_valid_ff;
   logic              c_last_ff;
   logic              c_start_ff;
   pass_kind_type     c_kind_ff;
   logic [CH_W-1:0]   c_diff_ff;
   logic              c_fire;
   logic [TODO_W-1:0] held_todo_ff;
   logic [CH_W-1:0]   held_max_ff;
   logic              compared_once_ff;
   logic [TODO_W-1:0] base_todo;
   logic [CH_W-1:0]   base_max;
   logic [TODO_W-1:0] todo_in;
   logic [CH_W-1:0]   max_in;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   // Stall stage C only when it holds a frame result and the output is full.
   assign c_ready = !c_valid_ff || !c_last_ff || !rsp_valid_ff || rsp_ready;
   assign c_fire  = c_valid_ff && c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         c_last_ff  <= b_last_ff;
         c_start_ff <= b_first_ff && (b_kind == PASS_COMPARE);
         c_kind_ff  <= b_kind;
         c_diff_ff  <= b_diff;
      end
   end

   // A compared pass starts its count and maximum from zero.
   always_comb begin
      base_todo = c_start_ff ? '0 : held_todo_ff;
      base_max  = c_start_ff ? '0 : held_max_ff;
      todo_in   = held_todo_ff;
      max_in    = held_max_ff;
      if (c_kind_ff == PASS_COMPARE) begin
         max_in  = (c_diff_ff > base_max) ? c_diff_ff : base_max;
         todo_in = base_todo;
         if (c_diff_ff > threshold_ff && base_todo != TODO_MAX) begin
            todo_in = base_todo + TODO_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_todo_ff     <= RESET_PIXELS;
         held_max_ff      <= ERROR_INF;
         compared_once_ff <= 1'b0;
      end else if (c_fire) begin
         held_todo_ff <= todo_in;
         held_max_ff  <= max_in;
         if (c_start_ff) begin
            compared_once_ff <= 1'b1;
         end
      end else if (csr_wen && csr_index_type'(csr_index) == CSR_FRAME_PIXELS
                   && !compared_once_ff) begin
         // Until the first comparison, track the frame size.
         held_todo_ff <= csr_eff_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_fire && c_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_fire && c_last_ff) begin
         rsp_payload_ff.todo_count <= todo_in;
         rsp_payload_ff.max_error  <= max_in;
         rsp_payload_ff.pass_kind  <= c_kind_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // No comparison can precede the first pass, so its error is still infinite.
   a_first_pass_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.pass_kind == PASS_FIRST)
      |-> (rsp_payload.max_error == ERROR_INF))
      else $error("first pass result with finite max_error");

   // A counted pixel exceeded the threshold, so the maximum must too.
   a_todo_implies_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.pass_kind == PASS_COMPARE
       && rsp_payload.todo_count != '0)
      |-> (rsp_payload.max_error > threshold_ff))
      else $error("nonzero todo_count with max_error not above threshold");

   // A forwarded reference must come from a write to the same entry.
   a_bypass_addr: assert property (@(posedge clock) disable iff (reset)
      ($past(req_fire) && byp_ff)
      |-> ($past(wr_en) && $past(b_addr_ff) == b_addr_ff))
      else $error("reference forwarded from a different entry");

   // A compared pass begins only on a frame's first pixel.
   a_start_first: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_start_ff) |-> (c_kind_ff == PASS_COMPARE && $past(b_first_ff)))
      else $error("compare start not at first pixel");
`endif

endmodule
